// ----- hw/rtl/websocket_frame_decoder_top_defines.svh -----
// assertion macros used by the frame decoder parser
`ifndef WEBSOCKET_FRAME_DECODER_TOP_DEFINES_SVH
`define WEBSOCKET_FRAME_DECODER_TOP_DEFINES_SVH

// same-cycle implication
`define WSFD_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("wsfd assertion failed");

// next-cycle implication
`define WSFD_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("wsfd assertion failed");

`endif

// ----- hw/rtl/wsfd_pkg.sv -----
// shared types and constants of the websocket frame decoder
package wsfd_pkg;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_CLOSE   = 2'd2;
  localparam logic [1:0] KIND_BINARY  = 2'd3;

  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_BINARY = 4'h2;

  localparam logic [6:0] LEN_EXT16 = 7'h7e;
  localparam logic [6:0] LEN_EXT64 = 7'h7f;

  localparam int QDEPTH = 2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [7:0] key;
    logic [3:0] opcode;
    logic       last;
  } cmd_t;

endpackage

// ----- hw/rtl/wsfd_parser.sv -----
// front end: header parsing and result classification, one byte per cycle while in_fire is high
`include "websocket_frame_decoder_top_defines.svh"

module wsfd_parser #(
  parameter int LENGTH_BITS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  logic [7:0]         in_byte,
  output logic               push,
  output wsfd_pkg::cmd_t     cmd
);

  localparam logic [2:0] PH_HDR0 = 3'd0;
  localparam logic [2:0] PH_HDR1 = 3'd1;
  localparam logic [2:0] PH_EXT  = 3'd2;
  localparam logic [2:0] PH_MASK = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_STOP = 3'd5;

  logic [2:0]             phase_r, phase_nxt;
  logic [2:0]             hcnt_r, hcnt_nxt;
  logic [3:0]             opcode_r, opcode_nxt;
  logic                   mask_on_r, mask_on_nxt;
  logic [LENGTH_BITS-1:0] rem_r, rem_nxt;
  logic [31:0]            key_r, key_nxt;
  logic [1:0]             mpos_r, mpos_nxt;

  logic [LENGTH_BITS-1:0] rem_ext;
  logic [LENGTH_BITS-1:0] rem_dec;
  logic [LENGTH_BITS-1:0] len_done;
  logic                   do_len_done;
  logic                   do_enter;
  logic [7:0]             key_byte;

  assign rem_ext = (rem_r[LENGTH_BITS-1 -: 8] != '0) ? '1 : {rem_r[LENGTH_BITS-9:0], in_byte};
  assign rem_dec = rem_r - LENGTH_BITS'(1);

  always_comb begin
    case (mpos_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt   = phase_r;
    hcnt_nxt    = hcnt_r;
    opcode_nxt  = opcode_r;
    mask_on_nxt = mask_on_r;
    rem_nxt     = rem_r;
    key_nxt     = key_r;
    mpos_nxt    = mpos_r;
    push        = 1'b0;
    cmd.kind    = wsfd_pkg::KIND_PAYLOAD;
    cmd.data    = 8'd0;
    cmd.key     = 8'd0;
    cmd.opcode  = opcode_r;
    cmd.last    = 1'b0;
    do_len_done = 1'b0;
    do_enter    = 1'b0;
    len_done    = rem_r;
    if (in_fire) begin
      unique case (phase_r)
        PH_HDR0: begin
          opcode_nxt = in_byte[3:0];
          phase_nxt  = PH_HDR1;
        end
        PH_HDR1: begin
          if (opcode_r == wsfd_pkg::OP_CLOSE) begin
            phase_nxt = PH_STOP;
            push      = 1'b1;
            cmd.kind  = wsfd_pkg::KIND_CLOSE;
          end else if (opcode_r == wsfd_pkg::OP_BINARY) begin
            phase_nxt = PH_STOP;
            push      = 1'b1;
            cmd.kind  = wsfd_pkg::KIND_BINARY;
          end else begin
            mask_on_nxt = in_byte[7];
            key_nxt     = 32'd0;
            if (in_byte[6:0] == wsfd_pkg::LEN_EXT16 || in_byte[6:0] == wsfd_pkg::LEN_EXT64) begin
              rem_nxt   = '0;
              hcnt_nxt  = (in_byte[6:0] == wsfd_pkg::LEN_EXT16) ? 3'd1 : 3'd7;
              phase_nxt = PH_EXT;
            end else begin
              len_done    = LENGTH_BITS'(in_byte[6:0]);
              rem_nxt     = len_done;
              do_len_done = 1'b1;
            end
          end
        end
        PH_EXT: begin
          rem_nxt = rem_ext;
          if (hcnt_r == 3'd0) begin
            len_done    = rem_ext;
            do_len_done = 1'b1;
          end else begin
            hcnt_nxt = hcnt_r - 3'd1;
          end
        end
        PH_MASK: begin
          key_nxt = {key_r[23:0], in_byte};
          if (hcnt_r == 3'd0) begin
            do_enter = 1'b1;
          end else begin
            hcnt_nxt = hcnt_r - 3'd1;
          end
        end
        PH_DATA: begin
          mpos_nxt = mpos_r + 2'd1;
          rem_nxt  = rem_dec;
          push     = 1'b1;
          cmd.kind = wsfd_pkg::KIND_PAYLOAD;
          cmd.data = in_byte;
          cmd.key  = mask_on_r ? key_byte : 8'd0;
          cmd.last = (rem_dec == '0);
          if (rem_dec == '0) begin
            phase_nxt = PH_HDR0;
          end
        end
        PH_STOP: begin
          phase_nxt = PH_STOP;
        end
        default: begin
          phase_nxt = PH_STOP;
        end
      endcase
      // length known: mask key next, or straight into payload, or back to HDR0 if the frame is empty
      if (do_len_done) begin
        if (mask_on_nxt) begin
          phase_nxt = PH_MASK;
          hcnt_nxt  = 3'd3;
        end else begin
          do_enter = 1'b1;
        end
      end
      if (do_enter) begin
        mpos_nxt = 2'd0;
        if (len_done == '0) begin
          phase_nxt = PH_HDR0;
          push      = 1'b1;
          cmd.kind  = wsfd_pkg::KIND_EMPTY;
          cmd.last  = 1'b1;
        end else begin
          phase_nxt = PH_DATA;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HDR0;
      hcnt_r    <= 3'd0;
      opcode_r  <= 4'd0;
      mask_on_r <= 1'b0;
      rem_r     <= '0;
      key_r     <= 32'd0;
      mpos_r    <= 2'd0;
    end else begin
      phase_r   <= phase_nxt;
      hcnt_r    <= hcnt_nxt;
      opcode_r  <= opcode_nxt;
      mask_on_r <= mask_on_nxt;
      rem_r     <= rem_nxt;
      key_r     <= key_nxt;
      mpos_r    <= mpos_nxt;
    end
  end

  `WSFD_ASSERT_NEXT(a_stop_sticks, clk, rst_n, phase_r == PH_STOP, phase_r == PH_STOP)
  `WSFD_ASSERT_IMP(a_payload_in_data, clk, rst_n, push && cmd.kind == wsfd_pkg::KIND_PAYLOAD, phase_r == PH_DATA)
  `WSFD_ASSERT_NEXT(a_status_stops, clk, rst_n, push && (cmd.kind == wsfd_pkg::KIND_CLOSE || cmd.kind == wsfd_pkg::KIND_BINARY), phase_r == PH_STOP)

endmodule

// ----- hw/rtl/wsfd_queue.sv -----
// two-entry result queue between parser and output stage
module wsfd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  wsfd_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output wsfd_pkg::cmd_t head_cmd
);

  wsfd_pkg::cmd_t mem [wsfd_pkg::QDEPTH];
  logic           wptr_r, wptr_nxt;
  logic           rptr_r, rptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           do_push;
  logic           do_pop;

  assign full       = (cnt_r == 2'(wsfd_pkg::QDEPTH));
  assign head_valid = (cnt_r != 2'd0);
  assign head_cmd   = mem[rptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wptr_nxt = do_push ? ~wptr_r : wptr_r;
    rptr_nxt = do_pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ----- hw/rtl/wsfd_unmask.sv -----
// back end: payload unmasking and registered result output
module wsfd_unmask (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  wsfd_pkg::cmd_t head_cmd,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     out_kind,
  output logic [7:0]     out_byte,
  output logic [3:0]     out_opcode,
  output logic           out_last
);

  logic       valid_r, valid_nxt;
  logic [1:0] kind_r;
  logic [7:0] byte_r;
  logic [3:0] opcode_r;
  logic       last_r;

  assign pop       = head_valid && (!valid_r || out_ready);
  assign valid_nxt = pop || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r   <= head_cmd.kind;
      byte_r   <= head_cmd.data ^ head_cmd.key;
      opcode_r <= head_cmd.opcode;
      last_r   <= head_cmd.last;
    end
  end

  assign out_valid  = valid_r;
  assign out_kind   = kind_r;
  assign out_byte   = byte_r;
  assign out_opcode = opcode_r;
  assign out_last   = last_r;

endmodule

// ----- hw/rtl/websocket_frame_decoder_top.sv -----
// websocket frame decoder: byte stream in, one result per cycle out while out_tready
// throughput: one byte per cycle, held only while the two-entry result queue is full
// a result goes through the result queue, then the output register behind out_tvalid
// the parser phase register and 64-bit length count set the per-byte loop
// reset: synchronous active-low rst_n clears parser state, queue and output valid
module websocket_frame_decoder_top #(
  parameter int LENGTH_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // in_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // payload_byte, frame_opcode, zero fill
  output logic [1:0]  out_tuser,  // result_kind
  output logic        out_tlast
);

  logic           in_fire;
  logic           push;
  wsfd_pkg::cmd_t push_cmd;
  logic           full;
  logic           pop;
  logic           head_valid;
  wsfd_pkg::cmd_t head_cmd;
  logic [7:0]     res_byte;
  logic [3:0]     res_opcode;

  assign in_tready = !full;
  assign in_fire   = in_tvalid && in_tready;

  wsfd_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_fire(in_fire),
    .in_byte(in_tdata),
    .push   (push),
    .cmd    (push_cmd)
  );

  wsfd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full),
    .pop       (pop),
    .head_valid(head_valid),
    .head_cmd  (head_cmd)
  );

  wsfd_unmask u_unmask (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head_cmd  (head_cmd),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_tuser),
    .out_byte  (res_byte),
    .out_opcode(res_opcode),
    .out_last  (out_tlast)
  );

  assign out_tdata = {4'd0, res_opcode, res_byte};

endmodule

// ----- sim/websocket_frame_decoder_top_test.sv -----
// self-checking testbench of the websocket frame decoder: byte stream in, predicted results out
`timescale 1ns / 100ps

module websocket_frame_decoder_top_test;

  localparam int LENGTH_BITS = 64;
  localparam logic [LENGTH_BITS-1:0] LEN_SATURATED = '1;

  localparam logic [2:0] PHASE_HDR0 = 3'd0;
  localparam logic [2:0] PHASE_HDR1 = 3'd1;
  localparam logic [2:0] PHASE_EXT  = 3'd2;
  localparam logic [2:0] PHASE_MASK = 3'd3;
  localparam logic [2:0] PHASE_DATA = 3'd4;
  localparam logic [2:0] PHASE_STOP = 3'd5;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [3:0] opcode;
    logic       last;
  } frame_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  websocket_frame_decoder_top #(.LENGTH_BITS(LENGTH_BITS)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // parser copy
  logic [2:0]               phase = PHASE_HDR0;
  logic [2:0]               hdr_left = '0;
  logic [3:0]               frame_op = '0;
  logic                     masked = 1'b0;
  logic [LENGTH_BITS-1:0]   bytes_left = '0;
  logic [31:0]              mask_word = '0;
  logic [1:0]               key_pos = '0;

  frame_result_t            pending_results[$];
  frame_result_t            oldest;
  int                       errors = 0;
  int                       sent_count = 0;
  bit                       no_idle = 1'b0;
  int                       ready_hold = 0;

  function void push_result(logic [1:0] kind, logic [7:0] data, logic last);
    frame_result_t r;
    r.kind   = kind;
    r.data   = data;
    r.opcode = frame_op;
    r.last   = last;
    pending_results.push_back(r);
  endfunction

  function void start_payload();
    key_pos = '0;
    if (bytes_left == 0) begin
      phase = PHASE_HDR0;
      push_result(wsfd_pkg::KIND_EMPTY, 8'h00, 1'b1);
    end else begin
      phase = PHASE_DATA;
    end
  endfunction

  function void length_known();
    if (masked) begin
      phase    = PHASE_MASK;
      hdr_left = 3'd3;
    end else begin
      start_payload();
    end
  endfunction

  function void parse_byte(logic [7:0] b);
    logic [7:0] v;
    case (phase)
      PHASE_HDR0: begin
        frame_op = b[3:0];
        phase    = PHASE_HDR1;
      end
      PHASE_HDR1: begin
        if (frame_op == wsfd_pkg::OP_CLOSE) begin
          phase = PHASE_STOP;
          push_result(wsfd_pkg::KIND_CLOSE, 8'h00, 1'b0);
        end else if (frame_op == wsfd_pkg::OP_BINARY) begin
          phase = PHASE_STOP;
          push_result(wsfd_pkg::KIND_BINARY, 8'h00, 1'b0);
        end else begin
          masked    = b[7];
          mask_word = '0;
          if (b[6:0] == wsfd_pkg::LEN_EXT16 || b[6:0] == wsfd_pkg::LEN_EXT64) begin
            bytes_left = '0;
            hdr_left   = (b[6:0] == wsfd_pkg::LEN_EXT16) ? 3'd1 : 3'd7;
            phase      = PHASE_EXT;
          end else begin
            bytes_left = LENGTH_BITS'(b[6:0]);
            length_known();
          end
        end
      end
      PHASE_EXT: begin
        if (bytes_left[LENGTH_BITS-1 -: 8] != 0) begin
          bytes_left = LEN_SATURATED;
        end else begin
          bytes_left = {bytes_left[LENGTH_BITS-9:0], b};
        end
        if (hdr_left == 0) begin
          length_known();
        end else begin
          hdr_left = hdr_left - 3'd1;
        end
      end
      PHASE_MASK: begin
        mask_word = {mask_word[23:0], b};
        if (hdr_left == 0) begin
          start_payload();
        end else begin
          hdr_left = hdr_left - 3'd1;
        end
      end
      PHASE_DATA: begin
        v = b;
        if (masked) begin
          v = v ^ mask_word[8 * (3 - key_pos) +: 8];
        end
        key_pos    = key_pos + 2'd1;
        bytes_left = bytes_left - 1;
        if (bytes_left == 0) begin
          phase = PHASE_HDR0;
        end
        push_result(wsfd_pkg::KIND_PAYLOAD, v, bytes_left == 0);
      end
      default: ;
    endcase
  endfunction

  function void check_field(string field, int want, int got);
    if (want != got) begin
      $display("%0t mismatch %s: expected %0h, actual %0h", $time, field, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: expected none, actual kind %0h data %0h op %0h last %0b",
                 $time, out_tuser, out_tdata[7:0], out_tdata[11:8], out_tlast);
        errors++;
      end else begin
        oldest = pending_results.pop_front();
        check_field("result_kind", int'(oldest.kind), int'(out_tuser));
        check_field("payload_byte", int'(oldest.data), int'(out_tdata[7:0]));
        check_field("frame_opcode", int'(oldest.opcode), int'(out_tdata[11:8]));
        check_field("last_of_message", int'(oldest.last), int'(out_tlast));
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (no_idle || $urandom_range(0, 1)) begin
      out_tready <= 1'b1;
      ready_hold <= $urandom_range(0, 15);
    end else begin
      out_tready <= 1'b0;
      ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 25) : $urandom_range(0, 2);
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [3:0] text_opcode();
    logic [3:0] op;
    op = 4'($urandom_range(0, 15));
    while (op == wsfd_pkg::OP_CLOSE || op == wsfd_pkg::OP_BINARY) begin
      op = 4'($urandom_range(0, 15));
    end
    return op;
  endfunction

  function automatic logic [7:0] rand_header0();
    logic [3:0] flags;
    flags = 4'($urandom_range(0, 15));
    return {flags, text_opcode()};
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    parse_byte(b);
    sent_count++;
  endtask

  // ext: 0 short length, 1 16-bit extended, 2 64-bit extended
  task automatic send_frame(input logic [7:0] hdr0, input bit with_mask, input int len,
                            input int ext, input logic [31:0] key);
    logic [63:0] len64;
    len64 = 64'(len);
    send_byte(hdr0);
    case (ext)
      0: send_byte({with_mask, len64[6:0]});
      1: begin
        send_byte({with_mask, wsfd_pkg::LEN_EXT16});
        send_byte(len64[15:8]);
        send_byte(len64[7:0]);
      end
      default: begin
        send_byte({with_mask, wsfd_pkg::LEN_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(len64[8 * i +: 8]);
      end
    endcase
    if (with_mask) begin
      for (int i = 3; i >= 0; i--) send_byte(key[8 * i +: 8]);
    end
    repeat (len) send_byte(8'($urandom_range(0, 255)));
  endtask

  // random bytes (no close or binary opcode, small extended lengths), run on until a frame boundary
  task automatic send_noise(input int n);
    logic [7:0] b;
    int i;
    i = 0;
    while (i < n || phase != PHASE_HDR0) begin
      b = 8'($urandom_range(0, 255));
      case (phase)
        PHASE_HDR0: begin
          if (b[3:0] == wsfd_pkg::OP_CLOSE || b[3:0] == wsfd_pkg::OP_BINARY) begin
            b[3:0] = text_opcode();
          end
        end
        PHASE_EXT: begin
          if (hdr_left == 1) begin
            b = 8'($urandom_range(0, 3));
          end else if (hdr_left > 1) begin
            b = 8'h00;
          end
        end
        default: ;
      endcase
      send_byte(b);
      i++;
    end
  endtask

  task automatic test_empty_frames();
    send_frame(8'h81, 1'b0, 0, 0, 32'h0);
    send_frame(8'h09, 1'b1, 0, 0, 32'hA5A5_5A5A);
  endtask

  task automatic test_masked_payload();
    send_frame(8'h71, 1'b1, 5, 0, 32'hFFFF_FFFF);
    send_frame(8'hFF, 1'b1, 3, 0, 32'h0000_0000);
    send_frame(8'h80, 1'b0, 1, 0, 32'h0);
  endtask

  task automatic test_extended_lengths();
    send_frame(8'h81, 1'b0, 0, 1, 32'h0);
    send_frame(8'h8A, 1'b1, 2, 1, 32'h0102_0304);
    send_frame(8'h81, 1'b0, 0, 2, 32'h0);
    send_frame(8'h83, 1'b0, 1, 2, 32'h0);
  endtask

  task automatic test_long_frames();
    send_frame(rand_header0(), 1'b1, 125, 0, $urandom());
    send_frame(rand_header0(), 1'b1, 300, 1, $urandom());
  endtask

  task automatic test_random_frames(input int target);
    int r;
    int len;
    int ext;
    bit with_mask;
    while (sent_count < target) begin
      no_idle   = ($urandom_range(0, 3) == 0);
      r         = $urandom_range(0, 99);
      with_mask = 1'($urandom_range(0, 1));
      ext       = 0;
      if (r < 65) begin
        len = $urandom_range(0, 12);
      end else if (r < 77) begin
        len = $urandom_range(13, 125);
      end else if (r < 87) begin
        ext = 1;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(126, 400) : $urandom_range(0, 20);
      end else begin
        ext = 2;
        len = $urandom_range(0, 20);
      end
      if (r < 94) begin
        send_frame(rand_header0(), with_mask, len, ext, $urandom());
      end else begin
        send_noise($urandom_range(1, 24));
      end
    end
    no_idle = 1'b0;
  endtask

  // close or binary stops the parser, so this runs last
  task automatic test_stop_frame();
    logic [3:0] flags;
    logic [3:0] op;
    flags = 4'($urandom_range(0, 15));
    op    = $urandom_range(0, 1) ? wsfd_pkg::OP_CLOSE : wsfd_pkg::OP_BINARY;
    send_byte({flags, op});
    send_byte(8'($urandom_range(0, 255)));
    repeat (12) send_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_frames();
    test_masked_payload();
    test_extended_lengths();
    test_long_frames();
    test_random_frames(1250);
    test_stop_frame();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/wsfd_pkg.sv
hw/rtl/wsfd_parser.sv
hw/rtl/wsfd_queue.sv
hw/rtl/wsfd_unmask.sv
hw/rtl/websocket_frame_decoder_top.sv
sim/websocket_frame_decoder_top_test.sv
